FILE: sv/vng_pkg.sv
// ----------------------------------------------------------------------------
// vng_pkg: shared types and constants for the vertex normal generator
// Holds the operation codes, fixed-point field widths and default sizes.
// ----------------------------------------------------------------------------
package vng_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Field widths: coordinates Q7.16, normals Q1.14, accumulators 24 bits.
  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int ACC_W   = 24;
  localparam int IDX_W   = 10;

  // Default number of vertex entries.
  localparam int DEFAULT_MAX_VERTICES = 1024;

endpackage

FILE: sv/vertex_normal_generator_top.sv
// ----------------------------------------------------------------------------
// vertex_normal_generator_top: smooth vertex normals for a triangle mesh
// Stores vertex positions, forms normalized face normals, accumulates them
// per vertex with saturation and returns the face normals and normalized vertex normals.
// ----------------------------------------------------------------------------
// The block works on one item at a time and takes a new item only when the
// sequencer is back in its idle state; a finished result sits in an output
// register so the next item can be accepted while it waits. A read item ends
// early when the accumulator is zero, and a triangle item when the face has
// zero area. Otherwise the run time varies with the normalizing shifter,
// which moves one bit per cycle until the largest magnitude lies in
// [2^29, 2^30). The rest of the work is done by a single shared 31x31
// multiplier used for all six cross-product terms and the three squares, a
// square root that resolves one result bit per cycle, and a restoring divider
// that produces one quotient bit per cycle for each of the three components.
// Corner indexes are reduced modulo MAX_VERTICES by a multiplication with a
// constant reciprocal and one correcting subtraction. Each store has one read
// port and one write port, and corners are read and accumulated one at a time.
// A result that cannot leave because the previous one is still unread holds
// the block in its last state until the output register drains.
module vertex_normal_generator_top #(
  parameter int MAX_VERTICES = vng_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [vng_pkg::IDX_W-1:0]           in_index_a,
  input  logic [vng_pkg::IDX_W-1:0]           in_index_b,
  input  logic [vng_pkg::IDX_W-1:0]           in_index_c,
  input  logic signed [vng_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [vng_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [vng_pkg::COORD_W-1:0]  in_coord_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vng_pkg::NORM_W-1:0]   out_normal_x,
  output logic signed [vng_pkg::NORM_W-1:0]   out_normal_y,
  output logic signed [vng_pkg::NORM_W-1:0]   out_normal_z,
  output logic                                out_degenerate
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = vng_pkg::COORD_W;
  localparam int PW = 3 * CW;
  // Reciprocal of the depth, scaled so the quotient estimate is low by at most one.
  localparam int RK = 2 * vng_pkg::IDX_W;
  localparam int MW = vng_pkg::IDX_W + 18;
  localparam logic [RK-1:0] RECIP = RK'((64'd1 << RK) / 64'(MAX_VERTICES));

  typedef enum logic [4:0] {
    S_IDLE, S_MOD, S_LOAD, S_RDPOS, S_EDGE, S_CROSS, S_RDACC, S_ABS,
    S_SHR, S_SHL, S_SQ, S_SQRT, S_DIVI, S_DIV, S_ACCRD, S_ACCWR, S_FIN
  } state_t;

  // Control registers.
  state_t            state_r;
  logic [5:0]        cnt_r;
  vng_pkg::op_t      op_r;
  logic              out_valid_r;

  // Index reduction.
  logic [vng_pkg::IDX_W-1:0] sa_r, sb_r, sc_r;
  logic [AW-1:0]             ra_r, rb_r, rc_r;

  // Datapath registers.
  logic [PW-1:0]       coord_r;
  logic [PW-1:0]       p_r [3];
  logic signed [24:0]  u_r [3];
  logic signed [24:0]  w_r [3];
  logic signed [61:0]  prod_r;
  logic signed [51:0]  cacc_r;
  logic signed [51:0]  c_r [3];
  logic [51:0]         m_r [3];
  logic [51:0]         mx_r;
  logic [62:0]         len_r;
  logic [62:0]         res_r;
  logic [62:0]         bit_r;
  logic [45:0]         rem_r;
  logic [14:0]         q_r;
  logic [1:0]          comp_r;
  logic signed [15:0]  n_r [3];
  logic                degen_r;

  // Output registers.
  logic signed [15:0]  out_nx_r, out_ny_r, out_nz_r;
  logic                out_degen_r;

  // Memories and their ports.
  logic [PW-1:0] pos_mem [MAX_VERTICES];
  logic [PW-1:0] acc_mem [MAX_VERTICES];
  logic [PW-1:0] pos_q, acc_q;
  logic [AW-1:0] pos_raddr, acc_raddr, acc_waddr;
  logic          pos_we, acc_we;
  logic [PW-1:0] acc_wdata;

  // Shared combinational step values.
  logic signed [30:0] mul_a, mul_b;
  logic [62:0]        sq_sum;
  logic               sq_ge;
  logic [30:0]        nrm;
  logic [45:0]        div_trial;
  logic               div_ge;
  logic [AW-1:0]      corner;
  logic signed [51:0] abs_in [3];
  logic [51:0]        abs_v [3];
  logic [51:0]        abs_max;

  // Index modulo the depth: quotient estimate by reciprocal, then one correction.
  function automatic logic [AW-1:0] mod_idx(input logic [vng_pkg::IDX_W-1:0] v);
    logic [vng_pkg::IDX_W+RK-1:0] prod;
    logic [vng_pkg::IDX_W-1:0]    q;
    logic [MW-1:0]                r;
    prod = (vng_pkg::IDX_W+RK)'(v) * (vng_pkg::IDX_W+RK)'(RECIP);
    q    = prod[vng_pkg::IDX_W+RK-1:RK];
    r    = MW'(v) - MW'(q) * MW'(MAX_VERTICES);
    if (r >= MW'(MAX_VERTICES)) begin
      r = r - MW'(MAX_VERTICES);
    end
    return r[AW-1:0];
  endfunction

  // Saturating add of a face normal component into an accumulator component.
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic signed [15:0] n);
    logic signed [CW:0] s;
    s = $signed({a[CW-1], a}) + (CW+1)'(n);
    if (s > $signed((CW+1)'((1 << (CW-1)) - 1))) begin
      s = (CW+1)'((1 << (CW-1)) - 1);
    end else if (s < -$signed((CW+1)'(1 << (CW-1)))) begin
      s = -$signed((CW+1)'(1 << (CW-1)));
    end
    return s[CW-1:0];
  endfunction

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_nx_r;
  assign out_normal_y   = out_ny_r;
  assign out_normal_z   = out_nz_r;
  assign out_degenerate = out_degen_r;

  // Corner index selected by the step counter.
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    corner = ra_r[AW-1:0];
      2'd1:    corner = rb_r[AW-1:0];
      default: corner = rc_r[AW-1:0];
    endcase
  end

  // Memory port control.
  assign pos_raddr = corner;
  assign pos_we    = (state_r == S_LOAD);
  assign acc_raddr = (state_r == S_RDACC) ? ra_r[AW-1:0] : corner;
  assign acc_waddr = (state_r == S_LOAD) ? ra_r[AW-1:0] : corner;
  assign acc_we    = (state_r == S_LOAD) || (state_r == S_ACCWR);
  assign acc_wdata = (state_r == S_LOAD) ? '0 :
                     {sat_add(acc_q[3*CW-1:2*CW], n_r[0]),
                      sat_add(acc_q[2*CW-1:CW], n_r[1]),
                      sat_add(acc_q[CW-1:0], n_r[2])};

  // Position store.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[ra_r[AW-1:0]] <= coord_r;
    end
    pos_q <= pos_mem[pos_raddr];
  end

  // Normal accumulator store.
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  // Multiplier operand selection: cross-product terms, then squares.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_CROSS) begin
      case (cnt_r[2:0])
        3'd0:    begin mul_a = 31'(u_r[1]); mul_b = 31'(w_r[2]); end
        3'd1:    begin mul_a = 31'(u_r[2]); mul_b = 31'(w_r[1]); end
        3'd2:    begin mul_a = 31'(u_r[2]); mul_b = 31'(w_r[0]); end
        3'd3:    begin mul_a = 31'(u_r[0]); mul_b = 31'(w_r[2]); end
        3'd4:    begin mul_a = 31'(u_r[0]); mul_b = 31'(w_r[1]); end
        default: begin mul_a = 31'(u_r[1]); mul_b = 31'(w_r[0]); end
      endcase
    end else begin
      case (cnt_r[1:0])
        2'd0:    mul_a = $signed({1'b0, m_r[0][29:0]});
        2'd1:    mul_a = $signed({1'b0, m_r[1][29:0]});
        default: mul_a = $signed({1'b0, m_r[2][29:0]});
      endcase
      mul_b = mul_a;
    end
  end

  // Square root step, divider step and magnitude of the vector.
  always_comb begin
    sq_sum    = res_r + bit_r;
    sq_ge     = (len_r >= sq_sum);
    nrm       = res_r[30:0];
    div_trial = 46'(nrm) << cnt_r[3:0];
    div_ge    = (rem_r >= div_trial);
    for (int i = 0; i < 3; i++) begin
      abs_in[i] = (op_r == vng_pkg::OP_READ) ? 52'($signed(c_r[i][CW-1:0])) : c_r[i];
      abs_v[i]  = abs_in[i][51] ? 52'(-abs_in[i]) : 52'(abs_in[i]);
    end
    abs_max = abs_v[0];
    if (abs_v[1] > abs_max) begin
      abs_max = abs_v[1];
    end
    if (abs_v[2] > abs_max) begin
      abs_max = abs_v[2];
    end
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Take an item and start index reduction.
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= vng_pkg::op_t'(in_operation);
            sa_r    <= in_index_a;
            sb_r    <= in_index_b;
            sc_r    <= in_index_c;
            coord_r <= {in_coord_x, in_coord_y, in_coord_z};
            for (int i = 0; i < 3; i++) begin
              n_r[i] <= '0;
            end
            degen_r <= 1'b0;
            cnt_r   <= '0;
            state_r <= S_MOD;
          end
        end
        // Reduce the three indexes modulo the store depth and dispatch.
        S_MOD: begin
          ra_r  <= mod_idx(sa_r);
          rb_r  <= mod_idx(sb_r);
          rc_r  <= mod_idx(sc_r);
          cnt_r <= '0;
          case (op_r)
            vng_pkg::OP_LOAD: state_r <= S_LOAD;
            vng_pkg::OP_TRI:  state_r <= S_RDPOS;
            vng_pkg::OP_READ: state_r <= S_RDACC;
            default:          state_r <= S_FIN;
          endcase
        end
        // Position and accumulator are written by the memory blocks.
        S_LOAD: begin
          state_r <= S_FIN;
        end
        // Read the three corner positions.
        S_RDPOS: begin
          if (cnt_r != 6'd0) begin
            p_r[cnt_r[1:0] - 2'd1] <= pos_q;
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) begin
            cnt_r   <= '0;
            state_r <= S_EDGE;
          end
        end
        // Edge vectors from corner 0.
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            u_r[i] <= 25'($signed(p_r[1][PW-1-i*CW -: CW]))
                    - 25'($signed(p_r[0][PW-1-i*CW -: CW]));
            w_r[i] <= 25'($signed(p_r[2][PW-1-i*CW -: CW]))
                    - 25'($signed(p_r[0][PW-1-i*CW -: CW]));
          end
          state_r <= S_CROSS;
        end
        // Cross product through the shared multiplier.
        S_CROSS: begin
          if (cnt_r != 6'd6) begin
            prod_r <= mul_a * mul_b;
          end
          if (cnt_r != 6'd0) begin
            if (cnt_r[0]) begin
              cacc_r <= prod_r[51:0];
            end else begin
              c_r[cnt_r[2:1] - 2'd1] <= cacc_r - prod_r[51:0];
            end
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd6) begin
            cnt_r   <= '0;
            state_r <= S_ABS;
          end
        end
        // Read one accumulator as the vector to normalize.
        S_RDACC: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd1) begin
            for (int i = 0; i < 3; i++) begin
              c_r[i] <= 52'($signed(acc_q[PW-1-i*CW -: CW]));
            end
            cnt_r   <= '0;
            state_r <= S_ABS;
          end
        end
        // Magnitudes and the largest one; a zero vector is degenerate.
        S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= abs_v[i];
          end
          mx_r <= abs_max;
          if (abs_max == '0) begin
            degen_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_SHR;
          end
        end
        // Scale down until the largest magnitude is below 2^30.
        S_SHR: begin
          if (mx_r[51:30] != '0) begin
            mx_r <= mx_r >> 1;
            for (int i = 0; i < 3; i++) begin
              m_r[i] <= m_r[i] >> 1;
            end
          end else begin
            state_r <= S_SHL;
          end
        end
        // Scale up until the largest magnitude reaches 2^29.
        S_SHL: begin
          if (!mx_r[29]) begin
            mx_r <= mx_r << 1;
            for (int i = 0; i < 3; i++) begin
              m_r[i] <= m_r[i] << 1;
            end
          end else begin
            len_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        // Sum of squares through the shared multiplier.
        S_SQ: begin
          if (cnt_r != 6'd3) begin
            prod_r <= mul_a * mul_b;
          end
          if (cnt_r != 6'd0) begin
            len_r <= len_r + 63'(prod_r);
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) begin
            res_r   <= '0;
            bit_r   <= 63'(1) << 62;
            state_r <= S_SQRT;
          end
        end
        // Integer square root, one result bit a cycle.
        S_SQRT: begin
          if (sq_ge) begin
            len_r <= len_r - sq_sum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 63'd1) begin
            comp_r  <= '0;
            state_r <= S_DIVI;
          end
        end
        // Load the rounded numerator for one component.
        S_DIVI: begin
          rem_r   <= {m_r[comp_r][29:0], 14'b0} + 46'(nrm >> 1);
          q_r     <= '0;
          cnt_r   <= 6'd14;
          state_r <= S_DIV;
        end
        // Restoring division, one quotient bit a cycle.
        S_DIV: begin
          if (div_ge) begin
            rem_r <= rem_r - div_trial;
          end
          q_r[cnt_r[3:0]] <= div_ge;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            if (c_r[comp_r][51] && op_r == vng_pkg::OP_TRI
                || op_r == vng_pkg::OP_READ && c_r[comp_r][CW-1]) begin
              n_r[comp_r] <= -$signed({1'b0, q_r[14:1], div_ge});
            end else begin
              n_r[comp_r] <= $signed({1'b0, q_r[14:1], div_ge});
            end
            comp_r <= comp_r + 2'd1;
            cnt_r  <= '0;
            if (comp_r == 2'd2) begin
              state_r <= (op_r == vng_pkg::OP_TRI) ? S_ACCRD : S_FIN;
            end else begin
              state_r <= S_DIVI;
            end
          end
        end
        // Read one corner's accumulator.
        S_ACCRD: begin
          state_r <= S_ACCWR;
        end
        // Saturating add of the face normal, written back by the memory block.
        S_ACCWR: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd2) begin
            cnt_r   <= '0;
            state_r <= S_FIN;
          end else begin
            state_r <= S_ACCRD;
          end
        end
        // Hand the result to the output register once it is free.
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_nx_r    <= n_r[0];
            out_ny_r    <= n_r[1];
            out_nz_r    <= n_r[2];
            out_degen_r <= degen_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A new item is never taken right after one was accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while sequencer busy");

  // A degenerate result always carries a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // Every component stays within the unit range.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384
      && out_normal_y <= 16'sd16384 && out_normal_y >= -16'sd16384
      && out_normal_z <= 16'sd16384 && out_normal_z >= -16'sd16384)
    else $error("normal component out of range");

  // The output register is only loaded when it is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_valid_r && !out_ready |=> state_r == S_FIN)
    else $error("pending result overwritten");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for vertex_normal_generator_top
// Drives load, triangle, read and undefined items over a valid/ready channel,
// predicts every result in a scoreboard and compares the results field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int NVERT       = 1024;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_WAIT  = 300;
  localparam int ACC_HI      = 8388607;
  localparam int ACC_LO      = -8388608;

  // Mesh state mirror that predicts one result per accepted item.
  class normal_scoreboard;
    typedef struct {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degen;
    } normal_res_t;

    int          position[NVERT][3];
    int          acc_sum[NVERT][3];
    normal_res_t expected_normals[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Scales the vector so its largest magnitude lies in [2^29, 2^30), then
    // divides each magnitude by the rounded-down length.
    function normal_res_t unit_normal(longint c0, longint c1, longint c2);
      normal_res_t     r;
      longint          c[3];
      longint unsigned m[3];
      longint unsigned mx, len2, len, q;
      c[0] = c0;
      c[1] = c1;
      c[2] = c2;
      mx = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
        if (m[i] > mx) mx = m[i];
      end
      r.nx = 0;
      r.ny = 0;
      r.nz = 0;
      r.degen = 1'b1;
      if (mx == 0) return r;
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
      len = int_sqrt(len2);
      r.degen = 1'b0;
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * 64'd16384 + len / 2) / len;
        if (c[i] < 0) q = -q;
        case (i)
          0: r.nx = q[15:0];
          1: r.ny = q[15:0];
          default: r.nz = q[15:0];
        endcase
      end
      return r;
    endfunction

    function void add_to_vertex(int v, normal_res_t n);
      int s[3];
      s[0] = acc_sum[v][0] + int'(n.nx);
      s[1] = acc_sum[v][1] + int'(n.ny);
      s[2] = acc_sum[v][2] + int'(n.nz);
      for (int i = 0; i < 3; i++) begin
        if (s[i] > ACC_HI) s[i] = ACC_HI;
        if (s[i] < ACC_LO) s[i] = ACC_LO;
        acc_sum[v][i] = s[i];
      end
    endfunction

    // Notes an accepted input item and queues its expected result.
    function void note_item(vng_pkg::op_t op, int a, int b, int c, int x, int y, int z);
      normal_res_t r;
      longint      u[3];
      longint      w[3];
      r.nx = 0;
      r.ny = 0;
      r.nz = 0;
      r.degen = 1'b0;
      a = a % NVERT;
      b = b % NVERT;
      c = c % NVERT;
      case (op)
        vng_pkg::OP_LOAD: begin
          position[a][0] = x;
          position[a][1] = y;
          position[a][2] = z;
          for (int i = 0; i < 3; i++) acc_sum[a][i] = 0;
        end
        vng_pkg::OP_TRI: begin
          for (int i = 0; i < 3; i++) begin
            u[i] = longint'(position[b][i]) - longint'(position[a][i]);
            w[i] = longint'(position[c][i]) - longint'(position[a][i]);
          end
          r = unit_normal(u[1] * w[2] - u[2] * w[1], u[2] * w[0] - u[0] * w[2],
                          u[0] * w[1] - u[1] * w[0]);
          add_to_vertex(a, r);
          add_to_vertex(b, r);
          add_to_vertex(c, r);
        end
        vng_pkg::OP_READ: begin
          r = unit_normal(acc_sum[a][0], acc_sum[a][1], acc_sum[a][2]);
        end
        default: begin
        end
      endcase
      expected_normals.push_back(r);
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(logic signed [15:0] nx, logic signed [15:0] ny,
                               logic signed [15:0] nz, logic dg);
      normal_res_t e;
      if (expected_normals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d %0d %0d deg %0b", nx, ny, nz, dg);
        return;
      end
      e = expected_normals.pop_front();
      if (nx !== e.nx || ny !== e.ny || nz !== e.nz || dg !== e.degen) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                   e.nx, e.ny, e.nz, e.degen, nx, ny, nz, dg);
      end
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [1:0]                         in_operation;
  logic [vng_pkg::IDX_W-1:0]          in_index_a;
  logic [vng_pkg::IDX_W-1:0]          in_index_b;
  logic [vng_pkg::IDX_W-1:0]          in_index_c;
  logic signed [vng_pkg::COORD_W-1:0] in_coord_x;
  logic signed [vng_pkg::COORD_W-1:0] in_coord_y;
  logic signed [vng_pkg::COORD_W-1:0] in_coord_z;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [vng_pkg::NORM_W-1:0]  out_normal_x;
  logic signed [vng_pkg::NORM_W-1:0]  out_normal_y;
  logic signed [vng_pkg::NORM_W-1:0]  out_normal_z;
  logic                               out_degenerate;

  normal_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  items_sent;
  int  quiet_cycles;
  bit  hold_req;
  bit  hold_done;
  bit  loaded[NVERT];
  int  vertex_pool[$];

  vertex_normal_generator_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_index_a     (in_index_a),
    .in_index_b     (in_index_b),
    .in_index_c     (in_index_c),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_normal_x   (out_normal_x),
    .out_normal_y   (out_normal_y),
    .out_normal_z   (out_normal_z),
    .out_degenerate (out_degenerate)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Monitor both channels and watch for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_normal_x, out_normal_y, out_normal_z, out_degenerate);
      if (in_valid && in_ready)
        sb.note_item(vng_pkg::op_t'(in_operation), in_index_a, in_index_b, in_index_c,
                     in_coord_x, in_coord_y, in_coord_z);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver, with one long hold-off so the block backs up.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one item and waits until it is accepted.
  task automatic send_item(vng_pkg::op_t op, int a, int b, int c, int x, int y, int z);
    if (items_sent < 550) begin
      send_idle_pct = 7;
      recv_idle_pct = 53;
    end else if (items_sent < 1100) begin
      send_idle_pct = 53;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_operation <= op;
    in_index_a   <= a[vng_pkg::IDX_W-1:0];
    in_index_b   <= b[vng_pkg::IDX_W-1:0];
    in_index_c   <= c[vng_pkg::IDX_W-1:0];
    in_coord_x   <= x[vng_pkg::COORD_W-1:0];
    in_coord_y   <= y[vng_pkg::COORD_W-1:0];
    in_coord_z   <= z[vng_pkg::COORD_W-1:0];
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == vng_pkg::OP_LOAD && !loaded[a % NVERT]) begin
      loaded[a % NVERT] = 1'b1;
      vertex_pool.push_back(a % NVERT);
    end
  endtask

  function automatic int pick_vertex();
    return vertex_pool[$urandom_range(vertex_pool.size() - 1)];
  endfunction

  // Coordinates: full range, small meshes, or edge values.
  function automatic int rand_coord();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom & 32'hFFFFFF);
      1: v = int'($urandom_range(1 << 19)) - (1 << 18);
      2: v = int'($urandom_range(1 << 13)) - (1 << 12);
      default: begin
        case ($urandom_range(4))
          0: v = 8388607;
          1: v = -8388608;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
    endcase
    if (v > 8388607) v = v - 16777216;
    return v;
  endfunction

  task automatic random_items(int count);
    int a, b, c, sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        a = ($urandom_range(3) == 0) ? pick_vertex() : $urandom_range(NVERT - 1);
        send_item(vng_pkg::OP_LOAD, a, 0, 0, rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 70) begin
        a = pick_vertex();
        b = pick_vertex();
        c = ($urandom_range(19) == 0) ? a : pick_vertex();
        send_item(vng_pkg::OP_TRI, a, b, c, rand_coord(), rand_coord(), rand_coord());
      end else if (sel < 95) begin
        send_item(vng_pkg::OP_READ, pick_vertex(), $urandom_range(NVERT - 1),
                  $urandom_range(NVERT - 1), rand_coord(), rand_coord(), rand_coord());
      end else begin
        send_item(vng_pkg::OP_NONE, $urandom_range(NVERT - 1), $urandom_range(NVERT - 1),
                  $urandom_range(NVERT - 1), rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  // Repeats one flat triangle until its corner accumulators saturate.
  task automatic saturate_run(int s0, int s1, int s2, bit flip);
    int r;
    send_item(vng_pkg::OP_LOAD, s0, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_LOAD, s1, 0, 0, 65536, 0, 0);
    send_item(vng_pkg::OP_LOAD, s2, 0, 0, 0, 65536, 0);
    for (int k = 0; k < 515; k++) begin
      r = $urandom_range(2);
      if (!flip) begin
        case (r)
          0: send_item(vng_pkg::OP_TRI, s0, s1, s2, 0, 0, 0);
          1: send_item(vng_pkg::OP_TRI, s1, s2, s0, 0, 0, 0);
          default: send_item(vng_pkg::OP_TRI, s2, s0, s1, 0, 0, 0);
        endcase
      end else begin
        case (r)
          0: send_item(vng_pkg::OP_TRI, s0, s2, s1, 0, 0, 0);
          1: send_item(vng_pkg::OP_TRI, s2, s1, s0, 0, 0, 0);
          default: send_item(vng_pkg::OP_TRI, s1, s0, s2, 0, 0, 0);
        endcase
      end
      if ($urandom_range(49) == 0) send_item(vng_pkg::OP_READ, s0, 0, 0, 0, 0, 0);
    end
    send_item(vng_pkg::OP_READ, s0, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_READ, s1, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_READ, s2, 0, 0, 0, 0, 0);
  endtask

  // Main sequence: reset, directed items, random items, drain and verdict.
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_index_a   = '0;
    in_index_b   = '0;
    in_index_c   = '0;
    in_coord_x   = '0;
    in_coord_y   = '0;
    in_coord_z   = '0;
    quiet_cycles = 0;
    items_sent   = 0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 53;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme positions, every operation, degenerate faces.
    send_item(vng_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_LOAD, 1, 0, 0, 65536, 0, 0);
    send_item(vng_pkg::OP_LOAD, 2, 0, 0, 0, 65536, 0);
    send_item(vng_pkg::OP_LOAD, 1023, 0, 0, 8388607, 8388607, 8388607);
    send_item(vng_pkg::OP_LOAD, 512, 0, 0, -8388608, -8388608, -8388608);
    send_item(vng_pkg::OP_LOAD, 341, 0, 0, 8388607, -8388608, 0);
    send_item(vng_pkg::OP_LOAD, 3, 0, 0, 131072, 0, 0);
    send_item(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_TRI, 0, 1, 2, 0, 0, 0);
    send_item(vng_pkg::OP_TRI, 1023, 512, 341, 0, 0, 0);
    send_item(vng_pkg::OP_TRI, 0, 0, 1, 0, 0, 0);
    send_item(vng_pkg::OP_TRI, 0, 1, 3, 0, 0, 0);
    send_item(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_READ, 1023, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_NONE, 1023, 1023, 1023, -1, -1, -1);
    send_item(vng_pkg::OP_TRI, 2, 1, 0, 0, 0, 0);
    send_item(vng_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_LOAD, 0, 0, 0, -1, -1, -1);
    send_item(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    send_item(vng_pkg::OP_READ, 2, 0, 0, 0, 0, 0);

    random_items(300);
    saturate_run(700, 701, 702, 1'b0);
    saturate_run(703, 704, 705, 1'b1);
    random_items(300);

    @(posedge clk);
    in_valid <= 1'b0;
    while (sb.expected_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.expected_normals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
